// ===== rtl/asc128_pkg.sv =====
// Shared types, constants and permutation helpers for the ASCON-128 engine.
package asc128_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LANE_COUNT = 5;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [WORD_W-1:0] ASCON_IV  = 64'h80400c0600000000;
  localparam logic [WORD_W-1:0] PAD_EMPTY = 64'h8000000000000000;

  localparam logic [3:0] FULL_BYTES = 4'd8;

  // round indexes: p12 starts at 0, p6 starts at 6, both end at 11
  localparam logic [3:0] ROUND_P12_FIRST = 4'd0;
  localparam logic [3:0] ROUND_P6_FIRST  = 4'd6;
  localparam logic [3:0] ROUND_LAST      = 4'd11;

  // input word kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_AD      = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_TAG     = 2'd3;

  // output word kinds
  localparam logic [1:0] OUT_PAYLOAD = 2'd0;
  localparam logic [1:0] OUT_TAG     = 2'd1;
  localparam logic [1:0] OUT_VERDICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HIGH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT_MODE = 3'd4;

  typedef logic [LANE_COUNT-1:0][WORD_W-1:0] lanes_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] data;
    logic [3:0]        byte_count;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_data;
    logic [3:0]        out_bytes;
    logic [1:0]        out_kind;
    logic              tag_ok;
    logic              last;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_INIT,
    OP_ROUND,
    OP_KEY_HEAD,
    OP_KEY_TAIL,
    OP_ABSORB,
    OP_PAD_EMPTY,
    OP_DOM_SEP,
    OP_PAYLOAD
  } lane_op_t;

  typedef enum logic [1:0] {
    EMIT_PAYLOAD,
    EMIT_TAG_HI,
    EMIT_TAG_LO,
    EMIT_VERDICT
  } emit_sel_t;

  typedef struct packed {
    logic       latch;
    lane_op_t   op;
    logic       dec;
    logic [3:0] rnd;
    logic       tag_idx;
    logic       emit;
    emit_sel_t  sel;
    logic       emit_last;
    logic       tag_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       tag_match;
    logic       out_free;
    logic       decrypt_mode;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] rotr(logic [WORD_W-1:0] x, int unsigned r);
    return (x >> r) | (x << (WORD_W - r));
  endfunction

  // one round of the permutation; constant is {15-i, i}
  function automatic lanes_t ascon_round(lanes_t s, logic [3:0] i);
    logic [WORD_W-1:0] x0, x1, x2, x3, x4;
    logic [WORD_W-1:0] t0, t1, t2, t3, t4;
    lanes_t r;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {56'd0, ~i, i};
    x3 = s[3];
    x4 = s[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = x0 ^ (~x1 & x2);
    t1 = x1 ^ (~x2 & x3);
    t2 = x2 ^ (~x3 & x4);
    t3 = x3 ^ (~x4 & x0);
    t4 = x4 ^ (~x0 & x1);
    t1 = t1 ^ t0;
    t0 = t0 ^ t4;
    t3 = t3 ^ t2;
    t2 = ~t2;
    r[0] = t0 ^ rotr(t0, 19) ^ rotr(t0, 28);
    r[1] = t1 ^ rotr(t1, 61) ^ rotr(t1, 39);
    r[2] = t2 ^ rotr(t2, 1) ^ rotr(t2, 6);
    r[3] = t3 ^ rotr(t3, 10) ^ rotr(t3, 17);
    r[4] = t4 ^ rotr(t4, 7) ^ rotr(t4, 41);
    return r;
  endfunction

  // leading n bytes set, n in 0..8
  function automatic logic [WORD_W-1:0] byte_mask(logic [3:0] n);
    logic [WORD_W-1:0] m;
    for (int k = 0; k < 8; k++) begin
      m[WORD_W-1-8*k -: 8] = (4'(k) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // padding byte 0x80 right after n data bytes, n in 0..7
  function automatic logic [WORD_W-1:0] pad_bits(logic [2:0] n);
    return 64'h80 << (6'd56 - {n, 3'b000});
  endfunction

endpackage

// ===== rtl/asc128_dp.sv =====
// Datapath: config registers, item register, state lanes, round unit, output register.
module asc128_dp
  import asc128_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  in_word_t               in_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             sts,
  input  logic                   out_stall,
  output logic                   out_valid,
  output out_word_t              out_word
);

  logic [WORD_W-1:0] key_high, key_low, nonce_high, nonce_low;
  logic              decrypt_mode;

  logic [1:0]        item_kind;
  logic [WORD_W-1:0] item_data;
  logic [3:0]        item_n;

  lanes_t            lanes;
  lanes_t            lanes_next;
  out_word_t         word_next;

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] din;
  logic [WORD_W-1:0] pad;
  logic              full;

  assign full = (item_n == FULL_BYTES);
  assign mask = byte_mask(item_n);
  assign din  = item_data & mask;
  assign pad  = full ? '0 : pad_bits(item_n[2:0]);

  assign sts.kind         = item_kind;
  assign sts.full         = full;
  assign sts.tag_match    = (item_data == (cmd.tag_idx ? lanes[4] : lanes[3]));
  assign sts.out_free     = !out_valid || !out_stall;
  assign sts.decrypt_mode = decrypt_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      nonce_high   <= '0;
      nonce_low    <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_HIGH:     key_high     <= cfg_data;
        CFG_KEY_LOW:      key_low      <= cfg_data;
        CFG_NONCE_HIGH:   nonce_high   <= cfg_data;
        CFG_NONCE_LOW:    nonce_low    <= cfg_data;
        CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp oversized byte counts to a full block
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind <= in_word.kind;
      item_data <= in_word.data;
      item_n    <= (in_word.byte_count > FULL_BYTES) ? FULL_BYTES : in_word.byte_count;
    end
  end

  always_comb begin
    lanes_next = lanes;
    case (cmd.op)
      OP_LOAD_INIT: begin
        lanes_next[0] = ASCON_IV;
        lanes_next[1] = key_high;
        lanes_next[2] = key_low;
        lanes_next[3] = nonce_high;
        lanes_next[4] = nonce_low;
      end
      OP_ROUND:     lanes_next = ascon_round(lanes, cmd.rnd);
      OP_KEY_HEAD: begin
        lanes_next[1] = lanes[1] ^ key_high;
        lanes_next[2] = lanes[2] ^ key_low;
      end
      OP_KEY_TAIL: begin
        lanes_next[3] = lanes[3] ^ key_high;
        lanes_next[4] = lanes[4] ^ key_low;
      end
      OP_ABSORB:    lanes_next[0] = lanes[0] ^ din ^ pad;
      OP_PAD_EMPTY: lanes_next[0] = lanes[0] ^ PAD_EMPTY;
      OP_DOM_SEP:   lanes_next[4] = lanes[4] ^ 64'd1;
      OP_PAYLOAD: begin
        if (cmd.dec) begin
          lanes_next[0] = ((lanes[0] & ~mask) | din) ^ pad;
        end else begin
          lanes_next[0] = lanes[0] ^ din ^ pad;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lanes <= lanes_next;
  end

  always_comb begin
    word_next.tag_ok = 1'b0;
    word_next.last   = cmd.emit_last;
    case (cmd.sel)
      EMIT_PAYLOAD: begin
        word_next.out_data  = (lanes[0] ^ din) & mask;
        word_next.out_bytes = item_n;
        word_next.out_kind  = OUT_PAYLOAD;
      end
      EMIT_TAG_HI: begin
        word_next.out_data  = lanes[3];
        word_next.out_bytes = FULL_BYTES;
        word_next.out_kind  = OUT_TAG;
      end
      EMIT_TAG_LO: begin
        word_next.out_data  = lanes[4];
        word_next.out_bytes = FULL_BYTES;
        word_next.out_kind  = OUT_TAG;
      end
      default: begin
        word_next.out_data  = '0;
        word_next.out_bytes = 4'd0;
        word_next.out_kind  = OUT_VERDICT;
        word_next.tag_ok    = cmd.tag_ok;
      end
    endcase
  end

  // output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== rtl/asc128_ctrl.sv =====
// Controller: message phase tracking and the per-word command sequencer.
module asc128_ctrl
  import asc128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_DISPATCH = 12'b000000000010,
    ST_ROUND    = 12'b000000000100,
    ST_INIT_KEY = 12'b000000001000,
    ST_AD_DONE  = 12'b000000010000,
    ST_DOM_SEP  = 12'b000000100000,
    ST_PAYLOAD  = 12'b000001000000,
    ST_KEY_HEAD = 12'b000010000000,
    ST_FIN_KEY  = 12'b000100000000,
    ST_TAG_HI   = 12'b001000000000,
    ST_TAG_LO   = 12'b010000000000,
    ST_VERDICT  = 12'b100000000000
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_AD   = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_TAG  = 4'b1000
  } phase_t;

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [3:0] rnd, rnd_next;
  phase_t     phase, phase_next;
  logic       dec, dec_next;
  logic       ad_seen, ad_seen_next;
  logic       tag_idx, tag_idx_next;
  logic       mismatch, mismatch_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.sel       = EMIT_PAYLOAD;
    cmd.tag_idx   = tag_idx;
    state_next    = state;
    ret_next      = ret;
    rnd_next      = rnd;
    phase_next    = phase;
    dec_next      = dec;
    ad_seen_next  = ad_seen;
    tag_idx_next  = tag_idx;
    mismatch_next = mismatch;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_IDLE;
        case (sts.kind)
          KIND_START: begin
            cmd.op     = OP_LOAD_INIT;
            rnd_next   = ROUND_P12_FIRST;
            ret_next   = ST_INIT_KEY;
            state_next = ST_ROUND;
          end
          KIND_AD: begin
            if (phase == PH_AD) begin
              cmd.op     = OP_ABSORB;
              rnd_next   = ROUND_P6_FIRST;
              ret_next   = ST_AD_DONE;
              state_next = ST_ROUND;
            end
          end
          KIND_PAYLOAD: begin
            if (phase == PH_AD) begin
              // close out associated data before the first payload word
              if (ad_seen) begin
                cmd.op     = OP_PAD_EMPTY;
                rnd_next   = ROUND_P6_FIRST;
                ret_next   = ST_DOM_SEP;
                state_next = ST_ROUND;
              end else begin
                state_next = ST_DOM_SEP;
              end
            end else if (phase == PH_PAY) begin
              state_next = ST_PAYLOAD;
            end
          end
          default: begin
            if (phase == PH_TAG) begin
              mismatch_next = mismatch || !sts.tag_match;
              if (!tag_idx) begin
                tag_idx_next = 1'b1;
              end else begin
                state_next = ST_VERDICT;
              end
            end
          end
        endcase
      end
      ST_ROUND: begin
        cmd.op  = OP_ROUND;
        cmd.rnd = rnd;
        if (rnd == ROUND_LAST) begin
          state_next = ret;
        end else begin
          rnd_next = rnd + 4'd1;
        end
      end
      ST_INIT_KEY: begin
        cmd.op        = OP_KEY_TAIL;
        phase_next    = PH_AD;
        dec_next      = sts.decrypt_mode;
        ad_seen_next  = 1'b0;
        tag_idx_next  = 1'b0;
        mismatch_next = 1'b0;
        state_next    = ST_IDLE;
      end
      ST_AD_DONE: begin
        if (!sts.full) begin
          cmd.op       = OP_DOM_SEP;
          phase_next   = PH_PAY;
          ad_seen_next = 1'b0;
        end else begin
          ad_seen_next = 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_DOM_SEP: begin
        cmd.op       = OP_DOM_SEP;
        phase_next   = PH_PAY;
        ad_seen_next = 1'b0;
        state_next   = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (sts.out_free) begin
          cmd.op        = OP_PAYLOAD;
          cmd.dec       = dec;
          cmd.emit      = 1'b1;
          cmd.sel       = EMIT_PAYLOAD;
          cmd.emit_last = sts.full || dec;
          if (sts.full) begin
            rnd_next   = ROUND_P6_FIRST;
            ret_next   = ST_IDLE;
            state_next = ST_ROUND;
          end else begin
            state_next = ST_KEY_HEAD;
          end
        end
      end
      ST_KEY_HEAD: begin
        cmd.op     = OP_KEY_HEAD;
        rnd_next   = ROUND_P12_FIRST;
        ret_next   = ST_FIN_KEY;
        state_next = ST_ROUND;
      end
      ST_FIN_KEY: begin
        cmd.op = OP_KEY_TAIL;
        if (dec) begin
          phase_next    = PH_TAG;
          tag_idx_next  = 1'b0;
          mismatch_next = 1'b0;
          state_next    = ST_IDLE;
        end else begin
          phase_next = PH_IDLE;
          state_next = ST_TAG_HI;
        end
      end
      ST_TAG_HI: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EMIT_TAG_HI;
          state_next = ST_TAG_LO;
        end
      end
      ST_TAG_LO: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = EMIT_TAG_LO;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_VERDICT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = EMIT_VERDICT;
          cmd.emit_last = 1'b1;
          cmd.tag_ok    = !mismatch;
          tag_idx_next  = 1'b0;
          phase_next    = PH_IDLE;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      rnd      <= ROUND_P12_FIRST;
      phase    <= PH_IDLE;
      dec      <= 1'b0;
      ad_seen  <= 1'b0;
      tag_idx  <= 1'b0;
      mismatch <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      rnd      <= rnd_next;
      phase    <= phase_next;
      dec      <= dec_next;
      ad_seen  <= ad_seen_next;
      tag_idx  <= tag_idx_next;
      mismatch <= mismatch_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit issued while output register is occupied and stalled");

  a_round_return: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == ROUND_LAST) |=> state == $past(ret))
    else $error("permutation did not return to its caller state");

  a_tag_wait_is_decrypt: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TAG |-> dec)
    else $error("tag wait entered in encrypt mode");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DISPATCH)
    else $error("accepted word not dispatched");

endmodule

// ===== rtl/ascon128_aead_engine.sv =====
// Top level of the ASCON-128 authenticated encryption engine.
// Input channel (in_valid / in_stall / in_word): one 64-bit word per accept.
//   kind start loads IV, key and nonce and runs p12; kind associated data
//   absorbs a block; kind payload encrypts or decrypts a block; kind tag
//   carries an expected tag word in decrypt mode. A byte_count below 8 marks
//   the final padded block; counts above 8 count as 8.
// Output channel (out_valid / out_stall / out_word): ciphertext or plaintext
//   blocks, the two tag words after an encrypt final block, and the pass/fail
//   verdict after the second expected tag word; last marks each word's final result.
// Configuration: cfg_write with cfg_index selects key_high, key_low,
//   nonce_high, nonce_low, decrypt_mode; write only while the engine is idle.
//   decrypt_mode is sampled by the start word.
// Timing: one permutation round per cycle sets the pace; a new word is accepted only
//   once the sequencer has finished the rounds and emits of the previous one.
// A result sits in an output register, so the next input word is accepted
//   while it waits; a stalled receiver only holds the sequencer when it has
//   another result to hand over. in_stall is high whenever a word is in work.
//   Reset (rst, synchronous) clears keys, nonce, mode, phase and out_valid.
module ascon128_aead_engine
  import asc128_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer: decides per word which lane operations, rounds and emits run
  asc128_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state lanes, round unit, config and output registers
  asc128_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ASCON-128 AEAD engine: random words, own cipher, scoreboard.
module testbench
  import asc128_pkg::*;
;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 24;   // quiet time with no result owed before a register write or a drain
  localparam int TAIL_CYCLES   = 40;
  localparam int MSG_WORDS     = 430;

  // message phase as the engine tracks it; the mode is latched by the start word
  typedef enum logic [2:0] {
    MSG_IDLE, MSG_ENC_AD, MSG_ENC_PAY, MSG_DEC_AD, MSG_DEC_PAY, MSG_TAG_WAIT
  } msg_phase_t;

  // what the sender does with one queued entry
  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_t;
  // where an expected tag word takes its data: literal, or the live tag halves
  typedef enum logic [1:0] {TAG_LITERAL, TAG_HI, TAG_LO} tag_src_t;

  typedef struct packed {
    act_t                   act;
    in_word_t               w;
    tag_src_t               src;
    logic [CFG_INDEX_W-1:0] idx;
    logic [WORD_W-1:0]      val;  // register value, or the flip mask of a tag word
  } tx_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;

  ascon128_aead_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cipher state and registers as the engine should hold them
  logic [WORD_W-1:0] st [5];
  msg_phase_t        msg_phase = MSG_IDLE;
  logic              ad_full_seen = 1'b0;
  logic              tag_second = 1'b0;
  logic              tag_bad = 1'b0;
  logic [WORD_W-1:0] key_hi = '0, key_lo = '0, nonce_hi = '0, nonce_lo = '0;
  logic              dec_mode = 1'b0;

  out_word_t ascon_out_q [$];   // results the engine still owes, oldest first
  tx_t       tx_q [$];          // words and register writes waiting to go out

  int  mismatches = 0;
  int  words_taken = 0;
  int  cfg_writes = 0;
  int  cycles = 0;
  int  settle = 0;
  int  planned = 0;
  int  payload_seen = 0, tag_seen = 0, verdict_pass = 0, verdict_fail = 0;
  logic gen_dec = 1'b0;         // mode the generated messages will run in

  task automatic flag_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("ERROR at %0t: %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Cipher
  // ---------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] ror64(logic [WORD_W-1:0] v, int k);
    return (v >> k) | (v << (64 - k));
  endfunction

  // leading n bytes of a word
  function automatic logic [WORD_W-1:0] lead_mask(int n);
    return (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
  endfunction

  // 0x80 right behind n data bytes
  function automatic logic [WORD_W-1:0] pad_after(int n);
    return 64'h80 << (56 - 8 * n);
  endfunction

  // run rounds first..11 over the state: p12 from 0, p6 from 6
  task automatic run_rounds(int first);
    logic [WORD_W-1:0] a, b, c, d, e, s0, s1, s2, s3, s4;
    for (int r = first; r < 12; r++) begin
      a = st[0] ^ st[4];
      b = st[1];
      c = st[2] ^ {56'd0, 4'(15 - r), 4'(r)} ^ st[1];
      d = st[3];
      e = st[4] ^ st[3];
      s0 = a ^ (~b & c);
      s1 = b ^ (~c & d);
      s2 = c ^ (~d & e);
      s3 = d ^ (~e & a);
      s4 = e ^ (~a & b);
      s1 = s1 ^ s0;
      s0 = s0 ^ s4;
      s3 = s3 ^ s2;
      s2 = ~s2;
      st[0] = s0 ^ ror64(s0, 19) ^ ror64(s0, 28);
      st[1] = s1 ^ ror64(s1, 61) ^ ror64(s1, 39);
      st[2] = s2 ^ ror64(s2, 1) ^ ror64(s2, 6);
      st[3] = s3 ^ ror64(s3, 10) ^ ror64(s3, 17);
      st[4] = s4 ^ ror64(s4, 7) ^ ror64(s4, 41);
    end
  endtask

  // finalization: key in, p12, key out; lanes 3 and 4 end up holding the tag
  task automatic squeeze_tag();
    st[1] ^= key_hi;
    st[2] ^= key_lo;
    run_rounds(0);
    st[3] ^= key_hi;
    st[4] ^= key_lo;
  endtask

  task automatic expect_result(logic [WORD_W-1:0] data, int bytes, logic [1:0] kind,
                               logic ok, logic fin);
    out_word_t o;
    o.out_data  = data;
    o.out_bytes = 4'(bytes);
    o.out_kind  = kind;
    o.tag_ok    = ok;
    o.last      = fin;
    ascon_out_q.push_back(o);
  endtask

  // advance the cipher by one accepted word and queue the results it owes
  task automatic ascon_process_word(in_word_t w);
    int n;
    logic [WORD_W-1:0] m, d;
    n = (w.byte_count > 4'd8) ? 8 : int'(w.byte_count);
    m = lead_mask(n);
    d = w.data & m;
    case (w.kind)
      KIND_START: begin
        st[0] = ASCON_IV;
        st[1] = key_hi;
        st[2] = key_lo;
        st[3] = nonce_hi;
        st[4] = nonce_lo;
        run_rounds(0);
        st[3] ^= key_hi;
        st[4] ^= key_lo;
        msg_phase = dec_mode ? MSG_DEC_AD : MSG_ENC_AD;
        ad_full_seen = 1'b0;
        tag_second = 1'b0;
        tag_bad = 1'b0;
      end
      KIND_AD: begin
        if (msg_phase == MSG_ENC_AD || msg_phase == MSG_DEC_AD) begin
          st[0] ^= d;
          if (n < 8) begin
            // short block closes the AD: pad, p6, domain separation
            st[0] ^= pad_after(n);
            run_rounds(6);
            st[4] ^= 64'd1;
            msg_phase = (msg_phase == MSG_DEC_AD) ? MSG_DEC_PAY : MSG_ENC_PAY;
            ad_full_seen = 1'b0;
          end else begin
            run_rounds(6);
            ad_full_seen = 1'b1;
          end
        end
      end
      KIND_PAYLOAD: begin
        if (msg_phase == MSG_ENC_AD || msg_phase == MSG_DEC_AD) begin
          // AD that ended on a full block still owes the empty padded block
          if (ad_full_seen) begin
            st[0] ^= pad_after(0);
            run_rounds(6);
          end
          st[4] ^= 64'd1;
          msg_phase = (msg_phase == MSG_DEC_AD) ? MSG_DEC_PAY : MSG_ENC_PAY;
          ad_full_seen = 1'b0;
        end
        if (msg_phase == MSG_ENC_PAY) begin
          st[0] ^= d;
          if (n == 8) begin
            expect_result(st[0], 8, OUT_PAYLOAD, 1'b0, 1'b1);
            run_rounds(6);
          end else begin
            expect_result(st[0] & m, n, OUT_PAYLOAD, 1'b0, 1'b0);
            st[0] ^= pad_after(n);
            squeeze_tag();
            expect_result(st[3], 8, OUT_TAG, 1'b0, 1'b0);
            expect_result(st[4], 8, OUT_TAG, 1'b0, 1'b1);
            msg_phase = MSG_IDLE;
          end
        end else if (msg_phase == MSG_DEC_PAY) begin
          expect_result((st[0] ^ d) & m, n, OUT_PAYLOAD, 1'b0, 1'b1);
          st[0] = (st[0] & ~m) | d;
          if (n == 8) begin
            run_rounds(6);
          end else begin
            st[0] ^= pad_after(n);
            squeeze_tag();
            msg_phase = MSG_TAG_WAIT;
            tag_second = 1'b0;
            tag_bad = 1'b0;
          end
        end
      end
      KIND_TAG: begin
        // all 64 bits count; the verdict comes with the second word only
        if (msg_phase == MSG_TAG_WAIT) begin
          if (!tag_second) begin
            if (w.data != st[3]) tag_bad = 1'b1;
            tag_second = 1'b1;
          end else begin
            if (w.data != st[4]) tag_bad = 1'b1;
            expect_result('0, 0, OUT_VERDICT, !tag_bad, 1'b1);
            tag_second = 1'b0;
            msg_phase = MSG_IDLE;
          end
        end
      end
    endcase
  endtask

  task automatic apply_cfg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
    case (idx)
      CFG_KEY_HIGH:     key_hi = val;
      CFG_KEY_LOW:      key_lo = val;
      CFG_NONCE_HIGH:   nonce_hi = val;
      CFG_NONCE_LOW:    nonce_lo = val;
      CFG_DECRYPT_MODE: dec_mode = val[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand64();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // full block: mostly 8, sometimes an oversized count
  function automatic logic [3:0] full_count();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : FULL_BYTES;
  endfunction

  task automatic push_word(logic [1:0] kind, logic [WORD_W-1:0] data, logic [3:0] n);
    tx_t t;
    t.act = ACT_WORD;
    t.w.kind = kind;
    t.w.data = data;
    t.w.byte_count = n;
    t.src = TAG_LITERAL;
    t.idx = '0;
    t.val = '0;
    tx_q.push_back(t);
    planned++;
  endtask

  task automatic push_tag(tag_src_t src, logic [WORD_W-1:0] flip);
    push_word(KIND_TAG, '0, 4'($urandom_range(0, 15)));
    tx_q[$].src = src;
    tx_q[$].val = flip;
  endtask

  task automatic push_cfg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
    tx_t t;
    t.act = ACT_CFG;
    t.w = '0;
    t.src = TAG_LITERAL;
    t.idx = idx;
    t.val = val;
    tx_q.push_back(t);
    if (idx == CFG_DECRYPT_MODE) gen_dec = val[0];
  endtask

  task automatic push_drain();
    tx_t t;
    t.act = ACT_DRAIN;
    t.w = '0;
    t.src = TAG_LITERAL;
    t.idx = '0;
    t.val = '0;
    tx_q.push_back(t);
  endtask

  // one message: start, AD, payload, and in decrypt mode the two tag words;
  // an unfinished one is cut off before its final block
  task automatic queue_message(bit finish);
    int n_ad, n_pay;
    logic [WORD_W-1:0] flip_hi, flip_lo;
    n_ad = $urandom_range(0, 3);
    n_pay = $urandom_range(0, 3);
    flip_hi = '0;
    flip_lo = '0;
    push_word(KIND_START, rand64(), 4'($urandom_range(0, 15)));
    for (int i = 0; i < n_ad; i++) push_word(KIND_AD, rand64(), full_count());
    if ($urandom_range(0, 1)) push_word(KIND_AD, rand64(), 4'($urandom_range(0, 7)));
    for (int i = 0; i < n_pay; i++) push_word(KIND_PAYLOAD, rand64(), full_count());
    if (finish) begin
      push_word(KIND_PAYLOAD, rand64(), 4'($urandom_range(0, 7)));
      if (gen_dec) begin
        // corrupt one tag half now and then
        case ($urandom_range(0, 5))
          0: flip_hi = 64'd1 << $urandom_range(0, 63);
          1: flip_lo = {$urandom, $urandom} | 64'd1;
          default: ;
        endcase
        push_tag(TAG_HI, flip_hi);
        push_tag(TAG_LO, flip_lo);
      end
    end
  endtask

  // quiet stretch: no idling on either side while these words go through
  function automatic bit quiet();
    return words_taken >= 150 && words_taken < 260;
  endfunction

  function automatic bit idle_roll();
    return !quiet() && ($urandom_range(0, 99) < 11);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued words; hold each one until it is taken; before a
  // register write or a drain mark, wait for every result plus the settle time
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic                   nxt_valid;
    in_word_t               nxt_word;
    logic                   nxt_wr;
    logic [CFG_INDEX_W-1:0] nxt_idx;
    logic [WORD_W-1:0]      nxt_cfg;
    tx_t                    t;
    nxt_valid = in_valid;
    nxt_word  = in_word;
    nxt_wr    = 1'b0;
    nxt_idx   = cfg_index;
    nxt_cfg   = cfg_data;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        ascon_process_word(in_word);
        words_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && tx_q.size() > 0) begin
        if (tx_q[0].act == ACT_WORD) begin
          settle = 0;
          if (!idle_roll()) begin
            t = tx_q.pop_front();
            nxt_word = t.w;
            // tag words follow the live tag, so fill them in only now
            if (t.src == TAG_HI) nxt_word.data = st[3] ^ t.val;
            if (t.src == TAG_LO) nxt_word.data = st[4] ^ t.val;
            nxt_valid = 1'b1;
          end
        end else if (ascon_out_q.size() == 0 && settle >= SETTLE_CYCLES) begin
          t = tx_q.pop_front();
          settle = 0;
          if (t.act == ACT_CFG) begin
            nxt_wr  = 1'b1;
            nxt_idx = t.idx;
            nxt_cfg = t.val;
            apply_cfg(t.idx, t.val);
            cfg_writes++;
          end
        end else begin
          settle = (ascon_out_q.size() == 0) ? settle + 1 : 0;
        end
      end
    end
    in_valid  <= nxt_valid;
    in_word   <= nxt_word;
    cfg_write <= nxt_wr;
    cfg_index <= nxt_idx;
    cfg_data  <= nxt_cfg;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest expectation, field by
  // field; stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (ascon_out_q.size() == 0) begin
        flag_mismatch("result with nothing expected", out_word.out_data, '0);
      end else begin
        want = ascon_out_q.pop_front();
        if (out_word.out_data !== want.out_data)
          flag_mismatch("out_data", out_word.out_data, want.out_data);
        if (out_word.out_bytes !== want.out_bytes)
          flag_mismatch("out_bytes", 64'(out_word.out_bytes), 64'(want.out_bytes));
        if (out_word.out_kind !== want.out_kind)
          flag_mismatch("out_kind", 64'(out_word.out_kind), 64'(want.out_kind));
        if (out_word.tag_ok !== want.tag_ok)
          flag_mismatch("tag_ok", 64'(out_word.tag_ok), 64'(want.tag_ok));
        if (out_word.last !== want.last)
          flag_mismatch("last", 64'(out_word.last), 64'(want.last));
        case (want.out_kind)
          OUT_PAYLOAD: payload_seen++;
          OUT_TAG:     tag_seen++;
          default: begin
            if (want.tag_ok) verdict_pass++;
            else verdict_fail++;
          end
        endcase
      end
    end
    out_stall <= !rst && idle_roll();
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, ascon_out_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and the end of the run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;

    // directed: extreme registers, every word kind, the corner cases
    push_cfg(CFG_KEY_HIGH, '1);
    push_cfg(CFG_KEY_LOW, '0);
    push_cfg(CFG_NONCE_HIGH, '0);
    push_cfg(CFG_NONCE_LOW, '1);
    push_cfg(CFG_DECRYPT_MODE, 64'd0);
    push_word(KIND_PAYLOAD, '1, FULL_BYTES);      // payload while idle: dropped
    push_word(KIND_START, '0, 4'd0);
    push_word(KIND_AD, '1, FULL_BYTES);
    push_word(KIND_AD, '0, 4'd15);                // oversized count, AD ends on full block
    push_word(KIND_PAYLOAD, '1, 4'd0);            // zero-byte final block
    push_word(KIND_AD, rand64(), 4'd3);           // AD after the message ended: dropped
    push_word(KIND_TAG, rand64(), FULL_BYTES);    // tag word outside tag wait: dropped
    push_word(KIND_START, '1, 4'd15);
    push_word(KIND_PAYLOAD, '1, FULL_BYTES);      // no AD at all
    push_word(KIND_PAYLOAD, '1, 4'd3);            // bytes past the count are junk
    push_word(KIND_START, rand64(), 4'd8);
    push_word(KIND_AD, rand64(), 4'd5);
    push_cfg(CFG_KEY_HIGH, rand64());             // key change mid-message
    push_word(KIND_PAYLOAD, rand64(), 4'd7);
    push_word(KIND_START, rand64(), 4'd2);
    push_word(KIND_AD, rand64(), FULL_BYTES);
    push_word(KIND_START, rand64(), 4'd1);        // restart aborts the open message
    push_word(KIND_PAYLOAD, rand64(), 4'd1);
    push_cfg(CFG_DECRYPT_MODE, 64'd1);
    push_word(KIND_START, rand64(), 4'd0);
    push_word(KIND_AD, rand64(), 4'd0);           // empty final AD block
    push_word(KIND_PAYLOAD, rand64(), 4'd0);      // decrypt zero-byte final
    push_tag(TAG_HI, '0);
    push_tag(TAG_LO, '0);
    push_word(KIND_START, rand64(), 4'd9);
    push_word(KIND_PAYLOAD, rand64(), 4'd4);
    push_tag(TAG_HI, 64'd1 << 63);                // bad first half
    push_tag(TAG_LO, '0);
    push_drain();

    // random: mostly whole messages, some register changes, noise, cut-off messages
    while (planned < MSG_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if ($urandom_range(0, 9) < 4) begin
          push_cfg(CFG_DECRYPT_MODE, 64'($urandom_range(0, 1)));
        end else begin
          push_cfg(CFG_INDEX_W'($urandom_range(0, 3)), rand64());
        end
      end else if (r < 16) begin
        push_word(2'($urandom_range(0, 3)), rand64(), 4'($urandom_range(0, 15)));
        planned--;
      end else if (r < 21) begin
        queue_message(1'b0);
      end else begin
        queue_message(1'b1);
      end
      if ($urandom_range(0, 11) == 0) push_drain();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for the last word to go out and every result to come back
    while (tx_q.size() != 0 || in_valid || ascon_out_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ascon_out_q.size() != 0)
      flag_mismatch("results never delivered", 64'(ascon_out_q.size()), '0);

    $display("Run: %0d input words taken, %0d register writes, %0d cycles.",
             words_taken, cfg_writes, cycles);
    $display("Checked %0d payload words, %0d tag words, %0d verdicts (%0d pass, %0d fail).",
             payload_seen, tag_seen, verdict_pass + verdict_fail, verdict_pass, verdict_fail);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
